// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// property that must hold in the cycle after its trigger
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/boxds_pkg.sv =====
// types, constants and channel arithmetic for the 2x2 box downscaler
`timescale 1ns / 1ps

package boxds_pkg;

  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned SUM_W         = CHAN_W + 1;
  localparam int unsigned DIM_W         = 11;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned REG_SEL_BIT   = 2;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // register index as decoded from the address
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] alpha;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } pair_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             restart;
  } cfg_t;

  function automatic pair_t pair_sum(pixel_t a, pixel_t b);
    pair_t r;
    r.red   = {1'b0, a.red}   + {1'b0, b.red};
    r.green = {1'b0, a.green} + {1'b0, b.green};
    r.blue  = {1'b0, a.blue}  + {1'b0, b.blue};
    r.alpha = {1'b0, a.alpha} + {1'b0, b.alpha};
    return r;
  endfunction

  function automatic chan_t chan_avg(logic [SUM_W-1:0] p, logic [SUM_W-1:0] q);
    logic [SUM_W:0] s;
    s = {1'b0, p} + {1'b0, q} + (SUM_W + 1)'(2);
    return s[SUM_W:2];
  endfunction

  function automatic pixel_t box_avg(pair_t p, pair_t q);
    pixel_t r;
    r.red   = chan_avg(p.red, q.red);
    r.green = chan_avg(p.green, q.green);
    r.blue  = chan_avg(p.blue, q.blue);
    r.alpha = chan_avg(p.alpha, q.alpha);
    return r;
  endfunction

endpackage

// ===== hw/rtl/boxds_regs.sv =====
// apb register block holding the frame size
`timescale 1ns / 1ps

module boxds_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [boxds_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [boxds_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [boxds_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output boxds_pkg::cfg_t                     cfg_o
);

  logic [boxds_pkg::DIM_W-1:0] width_q, width_d;
  logic [boxds_pkg::DIM_W-1:0] height_q, height_d;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[boxds_pkg::REG_SEL_BIT];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (reg_sel)
        boxds_pkg::REG_FRAME_WIDTH:  width_d  = pwdata[boxds_pkg::DIM_W-1:0];
        boxds_pkg::REG_FRAME_HEIGHT: height_d = pwdata[boxds_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= boxds_pkg::FRAME_WIDTH_RST;
      height_q <= boxds_pkg::FRAME_HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      boxds_pkg::REG_FRAME_WIDTH:  prdata = boxds_pkg::APB_DATA_W'(width_q);
      boxds_pkg::REG_FRAME_HEIGHT: prdata = boxds_pkg::APB_DATA_W'(height_q);
      default:                     prdata = '0;
    endcase
  end

  // any write restarts the frame
  assign cfg_o.frame_width  = width_q;
  assign cfg_o.frame_height = height_q;
  assign cfg_o.restart      = wr_en;

endmodule

// ===== hw/rtl/rgba_box_downscale_2x.sv =====
// rgba 2x2 box-filter downscaler, top level
// the input transfer completing a block goes through stage one, then the output register
// throughput: one input pixel per cycle unless the output stalls, one output per 2x2 block
// the single-port line store takes at most one write or one read per pixel
// reset: position counters and held pixel cleared, frame size 640x480, pipeline empty
// the line store is not cleared; every entry is written on an even row before it is read
`timescale 1ns / 1ps

module rgba_box_downscale_2x #(
  parameter int unsigned MAX_WIDTH  = boxds_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = boxds_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [boxds_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [boxds_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [boxds_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  // source pixel stream
  input  logic                              pix_valid_i,
  output logic                              pix_ready_o,
  input  logic [boxds_pkg::CHAN_W-1:0]      pix_red_i,
  input  logic [boxds_pkg::CHAN_W-1:0]      pix_green_i,
  input  logic [boxds_pkg::CHAN_W-1:0]      pix_blue_i,
  input  logic [boxds_pkg::CHAN_W-1:0]      pix_alpha_i,
  // downscaled pixel stream
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [boxds_pkg::CHAN_W-1:0]      out_red_o,
  output logic [boxds_pkg::CHAN_W-1:0]      out_green_o,
  output logic [boxds_pkg::CHAN_W-1:0]      out_blue_o,
  output logic [boxds_pkg::CHAN_W-1:0]      out_alpha_o,
  output logic                              end_of_frame_o
);

  // line store holds one pair sum per output column
  localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  // compare widths cover both the 11-bit register and the maximum
  localparam int unsigned WCMP_W = ($clog2(MAX_WIDTH + 1) > boxds_pkg::DIM_W) ?
                                   $clog2(MAX_WIDTH + 1) : boxds_pkg::DIM_W;
  localparam int unsigned HCMP_W = ($clog2(MAX_HEIGHT + 1) > boxds_pkg::DIM_W) ?
                                   $clog2(MAX_HEIGHT + 1) : boxds_pkg::DIM_W;

  boxds_pkg::cfg_t cfg;

  boxds_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // effective frame size: zero reads as one, oversize saturates to the maximum
  // ---------------------------------------------------------------------------
  logic [WCMP_W-1:0] w_raw, w_eff;
  logic [HCMP_W-1:0] h_raw, h_eff;

  assign w_raw = WCMP_W'(cfg.frame_width);
  assign h_raw = HCMP_W'(cfg.frame_height);

  always_comb begin
    priority if (w_raw == '0)                   w_eff = WCMP_W'(1);
    else if (w_raw > WCMP_W'(MAX_WIDTH))        w_eff = WCMP_W'(MAX_WIDTH);
    else                                        w_eff = w_raw;
  end

  always_comb begin
    priority if (h_raw == '0)                   h_eff = HCMP_W'(1);
    else if (h_raw > HCMP_W'(MAX_HEIGHT))       h_eff = HCMP_W'(MAX_HEIGHT);
    else                                        h_eff = h_raw;
  end

  // ---------------------------------------------------------------------------
  // input side: position, pair sum and line store access
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]        col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  boxds_pkg::pixel_t       held_q, held_d;
  boxds_pkg::pixel_t       pix_in;
  boxds_pkg::pair_t        pair;
  logic                    last_col, last_row;
  logic                    odd_col, odd_row;
  logic                    have_pair, do_store, do_emit;
  logic                    in_xfer;
  logic [LINE_AW-1:0]      line_idx;

  assign pix_in   = {pix_alpha_i, pix_blue_i, pix_green_i, pix_red_i};
  assign odd_col  = col_q[0];
  assign odd_row  = row_q[0];
  assign last_col = (WCMP_W'(col_q) + WCMP_W'(1)) >= w_eff;
  assign last_row = (HCMP_W'(row_q) + HCMP_W'(1)) >= h_eff;
  assign line_idx = LINE_AW'(col_q >> 1);

  // odd column pairs with the held even pixel; a lone last column pairs with itself
  assign pair      = odd_col ? boxds_pkg::pair_sum(held_q, pix_in)
                             : boxds_pkg::pair_sum(pix_in, pix_in);
  assign have_pair = odd_col | last_col;
  // even rows park their pair sums, except a lone last row which emits at once
  assign do_store  = have_pair & ~odd_row & ~last_row;
  assign do_emit   = have_pair & (odd_row | last_row);

  assign in_xfer = pix_valid_i & pix_ready_o;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (cfg.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (in_xfer) begin
      if (!odd_col && !last_col) begin
        held_d = pix_in;
      end
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      held_q <= held_d;
    end
  end

  // single-port line store with registered read
  boxds_pkg::pair_t line_mem_q [LINE_DEPTH];
  boxds_pkg::pair_t line_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && do_store) begin
      line_mem_q[line_idx] <= pair;
    end
    if (in_xfer && do_emit && odd_row) begin
      line_rd_q <= line_mem_q[line_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // stage one: pair sum waiting for the line store read
  // ---------------------------------------------------------------------------
  logic             s1_valid_q, s1_valid_d;
  boxds_pkg::pair_t s1_pair_q;
  logic             s1_use_line_q;
  logic             s1_eof_q;
  logic             out_free;
  logic             out_load;

  assign out_free    = ~out_valid_o | out_ready_i;
  assign out_load    = s1_valid_q & out_free;
  // stage one can take a new pixel when empty or moving on this cycle
  assign pix_ready_o = ~s1_valid_q | out_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = do_emit;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pair_q     <= pair;
      s1_use_line_q <= odd_row;
      s1_eof_q      <= last_col & last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // stage two: rounded average into the output register
  // ---------------------------------------------------------------------------
  boxds_pkg::pair_t  above;
  boxds_pkg::pixel_t out_pix_q;
  logic              out_eof_q;
  logic              out_valid_q, out_valid_d;

  // a lone last row is its own lower partner
  assign above = s1_use_line_q ? line_rd_q : s1_pair_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q <= boxds_pkg::box_avg(s1_pair_q, above);
      out_eof_q <= s1_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_pix_q.red;
  assign out_green_o    = out_pix_q.green;
  assign out_blue_o     = out_pix_q.blue;
  assign out_alpha_o    = out_pix_q.alpha;
  assign end_of_frame_o = out_eof_q;

endmodule

// ===== hw/rtl/boxds_checker.sv =====
// port-level checks for the box downscaler and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module boxds_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         pready,
  input logic                         pix_valid_i,
  input logic                         pix_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [boxds_pkg::CHAN_W-1:0] out_red_o,
  input logic [boxds_pkg::CHAN_W-1:0] out_green_o,
  input logic [boxds_pkg::CHAN_W-1:0] out_blue_o,
  input logic [boxds_pkg::CHAN_W-1:0] out_alpha_o,
  input logic                         end_of_frame_o
);

  // register port never inserts wait states
  `ASSERT_SAME(a_pready_high, clk_i, rst_ni, 1'b1, pready)

  // a stalled result keeps its value
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o) && $stable(out_alpha_o) && $stable(end_of_frame_o))

  // input backpressure only comes from a stalled, full output
  `ASSERT_SAME(a_ready_low_cause, clk_i, rst_ni, !pix_ready_o, out_valid_o && !out_ready_i)

  // a fresh result follows an input transfer through stage one and the output register
  `ASSERT_SAME(a_out_latency, clk_i, rst_ni, $rose(out_valid_o), $past(pix_valid_i && pix_ready_o, 2))

endmodule

bind rgba_box_downscale_2x boxds_checker u_boxds_checker (.*);

// ===== sim/rgba_box_downscale_2x_tb.sv =====
// self-checking testbench for the rgba 2x2 box-filter downscaler
`timescale 1ns / 1ps

module rgba_box_downscale_2x_tb;
  import boxds_pkg::*;

  // line store depth of the block, one entry per horizontal pixel pair
  localparam int unsigned LINE_ENTRIES = (MAX_WIDTH_DEF + 1) / 2;
  // cycles to let the pipeline run dry after the last expected output
  localparam int unsigned PIPE_PAD     = 4;
  // cap on the wait for outstanding outputs before giving up on them
  localparam int unsigned DRAIN_LIMIT  = 20000;
  // random stream length target
  localparam int unsigned RANDOM_PIXELS = 150;

  // channel 0 is red, then green, blue, alpha
  typedef logic [3:0][CHAN_W-1:0] quad_t;
  typedef logic [3:0][SUM_W-1:0]  quad_sum_t;

  // one downscaled pixel as the block should deliver it
  typedef struct {
    quad_t px;
    logic  eof;
  } box_t;

  // ---------------------------------------------------------------------------
  // clock, reset and dut ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  pix_valid_i = 1'b0;
  logic                  pix_ready_o;
  logic [CHAN_W-1:0]     pix_red_i   = '0;
  logic [CHAN_W-1:0]     pix_green_i = '0;
  logic [CHAN_W-1:0]     pix_blue_i  = '0;
  logic [CHAN_W-1:0]     pix_alpha_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CHAN_W-1:0]     out_red_o;
  logic [CHAN_W-1:0]     out_green_o;
  logic [CHAN_W-1:0]     out_blue_o;
  logic [CHAN_W-1:0]     out_alpha_o;
  logic                  end_of_frame_o;

  always #5 clk_i = ~clk_i;

  rgba_box_downscale_2x u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pix_valid_i   (pix_valid_i),
    .pix_ready_o   (pix_ready_o),
    .pix_red_i     (pix_red_i),
    .pix_green_i   (pix_green_i),
    .pix_blue_i    (pix_blue_i),
    .pix_alpha_i   (pix_alpha_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_alpha_o   (out_alpha_o),
    .end_of_frame_o(end_of_frame_o)
  );

  // ---------------------------------------------------------------------------
  // scoreboard state and the downscaler's shadow state
  // ---------------------------------------------------------------------------
  box_t              box_queue[$];     // downscaled pixels still owed by the block
  int unsigned       err_count  = 0;
  int unsigned       pix_count  = 0;   // source pixel transfers
  int unsigned       out_count  = 0;   // output transfers checked
  int unsigned       cfg_writes = 0;
  bit                calm       = 1'b0; // no gaps and no stalls when set

  // shadow registers, raw 11-bit values as written
  logic [DIM_W-1:0]  width_reg  = FRAME_WIDTH_RST;
  logic [DIM_W-1:0]  height_reg = FRAME_HEIGHT_RST;
  // position of the next source pixel within the frame
  int unsigned       col_pos    = 0;
  int unsigned       row_pos    = 0;
  // even-column pixel waiting for its right partner
  quad_t             held_px    = '0;
  // horizontal pair sums of the last even row
  quad_sum_t         line_sums[LINE_ENTRIES];

  string chan_name[4] = '{"red", "green", "blue", "alpha"};

  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // zero counts as one, anything past the maximum saturates
  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // per-channel 9-bit sums of two pixels
  function automatic quad_sum_t channel_pairs(quad_t a, quad_t b);
    quad_sum_t r;
    for (int c = 0; c < 4; c++) r[c] = SUM_W'(a[c]) + SUM_W'(b[c]);
    return r;
  endfunction

  // advance the shadow downscaler by one source pixel, queue any output it owes
  function automatic void predict_box(quad_t px);
    int unsigned w, h, idx;
    bit          last_c, last_r, have_pair, emit;
    quad_sum_t   pair, above;
    logic [SUM_W:0] total;
    box_t        res;
    w         = eff_dim(width_reg, MAX_WIDTH_DEF);
    h         = eff_dim(height_reg, MAX_HEIGHT_DEF);
    last_c    = (col_pos + 1 >= w);
    last_r    = (row_pos + 1 >= h);
    idx       = (col_pos / 2) % LINE_ENTRIES;
    have_pair = 1'b0;
    emit      = 1'b0;
    pair      = '0;
    if (col_pos % 2 == 0) begin
      // odd last column: the pixel is its own right partner
      if (last_c) begin
        pair      = channel_pairs(px, px);
        have_pair = 1'b1;
      end else begin
        held_px = px;
      end
    end else begin
      pair      = channel_pairs(held_px, px);
      have_pair = 1'b1;
    end
    if (have_pair) begin
      above = pair;
      if (row_pos % 2 == 0) begin
        // odd last row: the row is its own lower partner
        if (last_r) emit = 1'b1;
        else line_sums[idx] = pair;
      end else begin
        above = line_sums[idx];
        emit  = 1'b1;
      end
      if (emit) begin
        for (int c = 0; c < 4; c++) begin
          total     = (SUM_W + 1)'(pair[c]) + (SUM_W + 1)'(above[c]) + (SUM_W + 1)'(2);
          res.px[c] = total[SUM_W:2];
        end
        res.eof = last_c && last_r;
        box_queue.push_back(res);
      end
    end
    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: check every transfer against the oldest expectation and
  // throttle ready with random stall bursts
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin : out_check
    box_t  want;
    quad_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {out_alpha_o, out_blue_o, out_green_o, out_red_o};
      if (box_queue.size() == 0) begin
        flag_error($sformatf("output %h eof %0b with nothing expected", got, end_of_frame_o));
      end else begin
        want = box_queue.pop_front();
        for (int c = 0; c < 4; c++) begin
          if (got[c] !== want.px[c])
            flag_error($sformatf("%s expected %h got %h", chan_name[c], want.px[c], got[c]));
        end
        if (end_of_frame_o !== want.eof)
          flag_error($sformatf("end_of_frame expected %0b got %0b", want.eof, end_of_frame_o));
        out_count++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration port: setup cycle, access cycle until pready, then back to idle
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic idx, input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits are random, only the low 11 bits belong to the register
  task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
    logic [APB_DATA_W-1:0] word, unused;
    word             = $urandom();
    word[DIM_W-1:0]  = val;
    apb_xfer(1'b1, idx, word, unused);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    // any write restarts the frame, held pixel and line store stay
    col_pos = 0;
    row_pos = 0;
    cfg_writes++;
  endtask

  task automatic check_reg(input logic idx);
    logic [APB_DATA_W-1:0] rd, want;
    apb_xfer(1'b0, idx, '0, rd);
    want = APB_DATA_W'(idx == REG_FRAME_WIDTH ? width_reg : height_reg);
    if (rd !== want) flag_error($sformatf("register %0d read expected %h got %h", idx, want, rd));
  endtask

  // ---------------------------------------------------------------------------
  // source side
  // ---------------------------------------------------------------------------
  // one source pixel transfer, with an occasional gap first
  task automatic push_pixel(input quad_t px);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pix_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    pix_valid_i <= 1'b1;
    pix_red_i   <= px[0];
    pix_green_i <= px[1];
    pix_blue_i  <= px[2];
    pix_alpha_i <= px[3];
    do @(posedge clk_i); while (!pix_ready_o);
    predict_box(px);
    pix_count++;
  endtask

  // stop sending, wait for every owed output, then let the pipeline run dry
  task automatic settle();
    int unsigned waited;
    pix_valid_i <= 1'b0;
    waited = 0;
    while (box_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (box_queue.size() != 0) begin
      flag_error($sformatf("%0d expected outputs never arrived", box_queue.size()));
      box_queue.delete();
    end
    repeat (PIPE_PAD) @(posedge clk_i);
  endtask

  // channels lean toward 0 and 255 so saturation and zero sums come up often
  function automatic quad_t rand_pixel();
    quad_t px;
    int unsigned pick;
    for (int c = 0; c < 4; c++) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) px[c] = '0;
      else if (pick == 1) px[c] = '1;
      else px[c] = CHAN_W'($urandom_range(0, 255));
    end
    return px;
  endfunction

  task automatic stream_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_pixel(rand_pixel());
  endtask

  // mostly small sizes, sometimes zero, a mid size, or past the maximum
  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return DIM_W'($urandom_range(MAX_WIDTH_DEF + 1, 2047));
    if (pick == 2) return DIM_W'($urandom_range(13, 64));
    return DIM_W'($urandom_range(1, 12));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset size of 640x480: read back, then one full row and the start of the next
  task automatic test_reset_size();
    check_reg(REG_FRAME_WIDTH);
    check_reg(REG_FRAME_HEIGHT);
    stream_random(640 + 4);
    settle();
  endtask

  // hand-picked pixels on odd edges, a zero-size frame and rounding steps
  task automatic test_corner_blocks();
    quad_t odd_frame[9];
    quad_t one_px[3];
    quad_t rounding[8];
    // 3x3: odd last column pairs with itself, odd last row pairs with itself
    odd_frame = '{32'h00000000, 32'hFFFFFFFF, 32'h01020304,
                  32'hFF00FF00, 32'h00FF00FF, 32'h80808080,
                  32'h7F7F7F7F, 32'h01010101, 32'hFEFEFEFE};
    // zero width and height act as 1x1, every pixel is a whole frame
    one_px    = '{32'h00000000, 32'hFFFFFFFF, 32'h03030303};
    // 2x2 sums of 1 and 2 sit on either side of the rounding point
    rounding  = '{32'h00000000, 32'h00000000, 32'h00000000, 32'h01010101,
                  32'h00000000, 32'h00000000, 32'h01010101, 32'h01010101};
    write_reg(REG_FRAME_WIDTH, DIM_W'(3));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(3));
    foreach (odd_frame[i]) push_pixel(odd_frame[i]);
    settle();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    check_reg(REG_FRAME_WIDTH);
    foreach (one_px[i]) push_pixel(one_px[i]);
    settle();
    write_reg(REG_FRAME_WIDTH, DIM_W'(2));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(2));
    foreach (rounding[i]) push_pixel(rounding[i]);
    settle();
  endtask

  // a width past the maximum acts as 1024; the even row fills every line
  // store entry, the source holds off until all owed outputs are in, then
  // the start of the odd row reads back
  task automatic test_max_width();
    write_reg(REG_FRAME_WIDTH, DIM_W'(1500));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(2));
    stream_random(MAX_WIDTH_DEF);
    settle();
    stream_random(16);
    settle();
  endtask

  // 1-wide frame under a saturated height write, first rows only
  task automatic test_max_height();
    write_reg(REG_FRAME_WIDTH, DIM_W'(1));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(2047));
    check_reg(REG_FRAME_HEIGHT);
    stream_random(32);
    settle();
  endtask

  // random sizes, whole frames where they are small, partial ones otherwise
  task automatic test_random_frames();
    int unsigned used, len, w, h;
    bit          first;
    used  = 0;
    first = 1'b1;
    while (used < RANDOM_PIXELS) begin
      if (first || $urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, pick_dim());
      if (first || $urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, pick_dim());
      if ($urandom_range(0, 4) == 0) begin
        check_reg(REG_FRAME_WIDTH);
        check_reg(REG_FRAME_HEIGHT);
      end
      w = eff_dim(width_reg, MAX_WIDTH_DEF);
      h = eff_dim(height_reg, MAX_HEIGHT_DEF);
      if (w * h <= 100) len = w * h * $urandom_range(1, 2);
      else len = $urandom_range(20, 80);
      for (int unsigned i = 0; i < len; i++) begin
        // occasional full drain in mid-frame
        if ($urandom_range(0, 299) == 0) settle();
        push_pixel(rand_pixel());
      end
      used += len;
      first = 1'b0;
      settle();
    end
  endtask

  // back-to-back transfers with ready held high, two odd-sized frames
  task automatic test_no_idle();
    calm = 1'b1;
    write_reg(REG_FRAME_WIDTH, DIM_W'(7));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(5));
    stream_random(2 * 7 * 5);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_corner_blocks();
    test_max_width();
    test_max_height();
    test_random_frames();
    test_no_idle();
    settle();
    $display("covered %0d source pixels, %0d downscaled pixels checked, %0d register writes",
             pix_count, out_count, cfg_writes);
    $display("sizes from 1x1 up to the full line width, odd edges, clamped sizes, gaps and stalls");
    if (err_count == 0) begin
      $display("rgba_box_downscale_2x_tb: done, clean");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("rgba_box_downscale_2x_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("timeout with %0d outputs outstanding", box_queue.size());
    $display("rgba_box_downscale_2x_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/boxds_pkg.sv
hw/rtl/boxds_regs.sv
hw/rtl/rgba_box_downscale_2x.sv
hw/rtl/boxds_checker.sv
sim/rgba_box_downscale_2x_tb.sv
